### hdl/button_click_classifier_macros.svh
// Assertion macros used by the port-level checker of the click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define BCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bcc_pkg.sv
// Package with the types, phase codes and register indexes of the click classifier.
`default_nettype none

package bcc_pkg;

  localparam int TIME_BITS    = 32;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 8;
  localparam int PHASE_BITS   = 2;

  // Phase codes
  localparam logic [PHASE_BITS-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_PRESSED  = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_RELEASED = 2'd2;
  localparam logic [PHASE_BITS-1:0] PH_SECOND   = 2'd3;

  // Action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_ACK    = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_GAP = 8'd1;

  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd800;
  localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RESET = 16'd200;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic  action;
    logic  pin_level;
    time_t now_ms;
  } sample_t;

  typedef struct packed {
    logic                  clicked;
    logic                  double_clicked;
    logic                  long_clicked;
    logic [PHASE_BITS-1:0] phase;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] long_press_ms;
    logic [CFG_BITS-1:0] double_gap_ms;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/bcc_if.sv
// Channel interfaces of the click classifier: samples, results and register writes.
`default_nettype none

interface bcc_sample_if import bcc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  logic  pin_level;
  time_t now_ms;

  modport source (output valid, output action, output pin_level, output now_ms, input ready);
  modport sink (input valid, input action, input pin_level, input now_ms, output ready);
endinterface

interface bcc_result_if import bcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  clicked;
  logic                  double_clicked;
  logic                  long_clicked;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output clicked, output double_clicked, output long_clicked,
                  output phase, input ready);
  modport sink (input valid, input clicked, input double_clicked, input long_clicked,
                input phase, output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/bcc_cfg_regs.sv
// Configuration registers of the click classifier.
`default_nettype none

module bcc_cfg_regs import bcc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [CFG_IDX_BITS-1:0] wr_index,
  input  wire logic [CFG_BITS-1:0]     wr_data,
  output cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms <= LONG_PRESS_RESET;
      cfg.double_gap_ms <= DOUBLE_GAP_RESET;
    end else if (wr_en) begin
      // drop writes to unused indexes
      case (wr_index)
        REG_LONG_PRESS: cfg.long_press_ms <= wr_data;
        REG_DOUBLE_GAP: cfg.double_gap_ms <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bcc_core.sv
// Click phase machine, stored times and sticky click flags.
`default_nettype none

module bcc_core import bcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire sample_t item,
  input  wire cfg_t    cfg,
  output result_t      result_next
);

  logic [PHASE_BITS-1:0] phase, phase_next;
  time_t                 press_time, press_time_next;
  time_t                 release_time, release_time_next;
  logic                  single_flag, single_flag_next;
  logic                  double_flag, double_flag_next;
  logic                  long_flag, long_flag_next;

  time_t press_dt;
  time_t release_dt;
  time_t long_lim;
  time_t gap_lim;

  // Modular elapsed times
  assign press_dt   = item.now_ms - press_time;
  assign release_dt = item.now_ms - release_time;
  assign long_lim   = time_t'(cfg.long_press_ms);
  assign gap_lim    = time_t'(cfg.double_gap_ms);

  always_comb begin
    phase_next        = phase;
    press_time_next   = press_time;
    release_time_next = release_time;
    single_flag_next  = single_flag;
    double_flag_next  = double_flag;
    long_flag_next    = long_flag;
    if (item.action == ACT_ACK) begin
      single_flag_next = 1'b0;
      double_flag_next = 1'b0;
      long_flag_next   = 1'b0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (!item.pin_level) begin
            phase_next      = PH_PRESSED;
            press_time_next = item.now_ms;
          end
        end
        PH_PRESSED: begin
          if (item.pin_level) begin
            if (press_dt < long_lim) begin
              phase_next        = PH_RELEASED;
              release_time_next = item.now_ms;
            end else begin
              phase_next     = PH_IDLE;
              long_flag_next = 1'b1;
            end
          end
        end
        PH_RELEASED: begin
          if (item.pin_level && (release_dt > gap_lim)) begin
            phase_next       = PH_IDLE;
            single_flag_next = 1'b1;
          end else if (!item.pin_level && (release_dt < gap_lim)) begin
            phase_next = PH_SECOND;
          end
        end
        default: begin
          if (item.pin_level) begin
            phase_next       = PH_IDLE;
            double_flag_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      press_time   <= '0;
      release_time <= '0;
      single_flag  <= 1'b0;
      double_flag  <= 1'b0;
      long_flag    <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
      single_flag  <= single_flag_next;
      double_flag  <= double_flag_next;
      long_flag    <= long_flag_next;
    end
  end

  assign result_next.clicked        = single_flag_next;
  assign result_next.double_clicked = double_flag_next;
  assign result_next.long_clicked   = long_flag_next;
  assign result_next.phase          = phase_next;

endmodule

`default_nettype wire

### hdl/button_click_classifier.sv
// Top level of the single, double and long click classifier.
// Usage:
//   samples: one transaction per pin sample (action 0) or acknowledge (action 1).
//     A sample carries the active-low pin level and a wrapping millisecond time.
//   results: exactly one transaction per sample transaction, in order, holding
//     the sticky click flags and the phase after that item is applied.
//   cfg: register writes, index 0 long press time, index 1 double click gap.
//     Write only while no item is in flight; other indexes are ignored.
// Path: a sample loads the input register at the accepting edge and moves to
//   the result register when that slot frees up; the result is offered from
//   the result register.
// Throughput: one item per cycle while results are taken, set by the phase update loop.
// Reset (rst, synchronous): phase idle, times and flags cleared, registers
//   back to 800 ms and 200 ms; both input channels hold ready low during reset.
// Stall: when results is not taken, the result register holds and the input
//   register fills; then samples.ready drops until the result is taken.
`default_nettype none

module button_click_classifier import bcc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  bcc_sample_if.sink     samples,
  bcc_result_if.source   results,
  bcc_cfg_if.sink        cfg
);

  sample_t s1_item;
  logic    s1_valid;
  logic    advance;
  cfg_t    cfg_q;
  result_t result_next;
  result_t result_q;
  logic    out_valid;
  logic    in_take;

  // Register writes are always accepted outside reset
  assign cfg.ready = !rst;

  bcc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // Advance the staged item into the result register when that slot frees up
  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !rst && (!s1_valid || advance);
  assign in_take       = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.action    <= samples.action;
      s1_item.pin_level <= samples.pin_level;
      s1_item.now_ms    <= samples.now_ms;
    end
  end

  // State moves on exactly once per item, when it enters the result register
  bcc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (s1_item),
    .cfg         (cfg_q),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_next;
    end
  end

  assign results.valid          = out_valid;
  assign results.clicked        = result_q.clicked;
  assign results.double_clicked = result_q.double_clicked;
  assign results.long_clicked   = result_q.long_clicked;
  assign results.phase          = result_q.phase;

endmodule

`default_nettype wire

### hdl/bcc_checker.sv
// Port-level checker of the click classifier and its bind to the top level.
`default_nettype none
`include "button_click_classifier_macros.svh"

module bcc_checker import bcc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_valid,
  input wire logic                  s_ready,
  input wire logic                  r_valid,
  input wire logic                  r_ready,
  input wire logic                  r_clicked,
  input wire logic                  r_double,
  input wire logic                  r_long,
  input wire logic [PHASE_BITS-1:0] r_phase
);

  `BCC_ASSERT_NEXT(a_result_holds, clk, rst, r_valid && !r_ready, r_valid, "result dropped while stalled")
  `BCC_ASSERT_NEXT(a_result_stable, clk, rst, r_valid && !r_ready, $stable({r_clicked, r_double, r_long, r_phase}), "result changed while stalled")
  `BCC_ASSERT_NOW(a_result_has_source, clk, rst, $rose(r_valid), $past(s_valid && s_ready, 2), "result offered without a sample two cycles before")
  `BCC_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !r_valid, "result offered right after reset")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (samples.valid),
  .s_ready   (samples.ready),
  .r_valid   (results.valid),
  .r_ready   (results.ready),
  .r_clicked (results.clicked),
  .r_double  (results.double_clicked),
  .r_long    (results.long_clicked),
  .r_phase   (results.phase)
);

`default_nettype wire

### tb/button_click_classifier_test.sv
// Self-checking testbench of the click classifier: directed table, then random click gestures.
`timescale 1ns / 100ps

module button_click_classifier_test;
  import bcc_pkg::*;

  // Idle cycles with no handshake at all before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to keep watching after the last result has been taken.
  localparam int TAIL_CYCLES = 8;
  // Random items per segment; nine segments give about 700.
  localparam int SEG_ITEMS = 78;
  // First register index that the block must ignore.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = REG_DOUBLE_GAP + 1'b1;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed table: either a sample or acknowledge transaction,
  // or a register write. When chk is set, lit is the result typed in by hand.
  typedef struct packed {
    row_kind_t               kind;
    logic                    act;
    logic                    pin;
    time_t                   t;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_BITS-1:0]     data;
    logic                    chk;
    result_t                 lit;
  } dir_row_t;

  logic clk;
  logic rst;

  bcc_sample_if sample_ch ();
  bcc_result_if result_ch ();
  bcc_cfg_if    reg_ch ();

  button_click_classifier u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (reg_ch)
  );

  // Predictor copy of the classifier: phase, press and release stamps, sticky
  // flags, and the two timing registers as last written.
  logic [PHASE_BITS-1:0] st_phase;
  time_t                 st_press_ms;
  time_t                 st_release_ms;
  logic                  st_single;
  logic                  st_double;
  logic                  st_long;
  logic [CFG_BITS-1:0]   set_long_ms;
  logic [CFG_BITS-1:0]   set_gap_ms;

  // Flag and phase status still owed by the block, oldest first.
  result_t status_due [$];

  // Hand-typed result that travels with the sample currently on the channel.
  logic    row_chk;
  result_t row_lit;

  int          n_fail;
  int          quiet_cycles;
  int          items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  time_t       clock_ms;
  time_t       base_ms;

  dir_row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the status after one transaction and advance the predictor state.
  function automatic result_t classify(input logic act, input logic pin, input time_t t);
    time_t dt;
    if (act == ACT_ACK) begin
      // Acknowledge: drop the flags, leave phase and stamps alone.
      st_single = 1'b0;
      st_double = 1'b0;
      st_long   = 1'b0;
    end else begin
      case (st_phase)
        PH_IDLE: begin
          if (!pin) begin
            st_phase    = PH_PRESSED;
            st_press_ms = t;
          end
        end
        PH_PRESSED: begin
          if (pin) begin
            dt = t - st_press_ms;  // wraps modulo 2^32 by width
            if (dt < time_t'(set_long_ms)) begin
              st_phase      = PH_RELEASED;
              st_release_ms = t;
            end else begin
              st_phase = PH_IDLE;
              st_long  = 1'b1;
            end
          end
        end
        PH_RELEASED: begin
          dt = t - st_release_ms;
          // Released exactly at the gap, or pressed at or past it: no change.
          if (pin && dt > time_t'(set_gap_ms)) begin
            st_phase  = PH_IDLE;
            st_single = 1'b1;
          end else if (!pin && dt < time_t'(set_gap_ms)) begin
            st_phase = PH_SECOND;
          end
        end
        default: begin
          if (pin) begin
            st_phase  = PH_IDLE;
            st_double = 1'b1;
          end
        end
      endcase
    end
    return '{st_single, st_double, st_long, st_phase};
  endfunction

  function automatic result_t status(input logic c, input logic d, input logic l,
                                     input logic [PHASE_BITS-1:0] ph);
    return '{c, d, l, ph};
  endfunction

  function automatic dir_row_t lit_row(input logic act, input logic pin, input time_t t,
                                       input result_t want);
    return '{ROW_ITEM, act, pin, t, '0, '0, 1'b1, want};
  endfunction

  function automatic dir_row_t free_row(input logic act, input logic pin, input time_t t);
    return '{ROW_ITEM, act, pin, t, '0, '0, 1'b0, '0};
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [CFG_BITS-1:0] data);
    return '{ROW_REG, ACT_SAMPLE, 1'b1, '0, idx, data, 1'b0, '0};
  endfunction

  // Pick an elapsed time that lands on, next to, or well around a threshold.
  function automatic int unsigned around(input int unsigned thr);
    case ($urandom_range(0, 7))
      0: return (thr == 0) ? 0 : thr - 1;
      1: return thr;
      2: return thr + 1;
      3, 4: return $urandom_range(0, thr);
      5, 6: return $urandom_range(thr, 2 * thr + 2);
      default: return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
    endcase
  endfunction

  // Pick an elapsed time strictly below a threshold, often the last one below.
  function automatic int unsigned short_of(input int unsigned thr);
    if (thr == 0) return 0;
    if ($urandom_range(0, 3) == 0) return thr - 1;
    return $urandom_range(0, thr - 1);
  endfunction

  // Offer one transaction on the sample channel; called and returns at a falling edge.
  // Valid stays high into the next call unless the sender decides to idle.
  task automatic put_sample(input logic act, input logic pin, input time_t t,
                            input logic chk, input result_t lit);
    reg_ch.valid <= 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.action    <= act;
    sample_ch.pin_level <= pin;
    sample_ch.now_ms    <= t;
    row_chk             <= chk;
    row_lit             <= lit;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold the sender off until every owed result has been taken.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    reg_ch.valid    <= 1'b0;
    do @(negedge clk); while (status_due.size() != 0);
  endtask

  // Write one register; valid stays high so back-to-back writes stream.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk); while (reg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_BITS-1:0] lp, input logic [CFG_BITS-1:0] gp);
    drain();
    write_reg(REG_LONG_PRESS, lp);
    // Sprinkle writes to indexes the block must ignore.
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_IDX_BITS'($urandom_range(REG_DOUBLE_GAP + 1, 255)),
                CFG_BITS'($urandom));
    write_reg(REG_DOUBLE_GAP, gp);
  endtask

  // Sample the pin at an offset from the gesture start, with the odd acknowledge
  // slipped in ahead of it.
  task automatic tap(input logic pin, input int unsigned off);
    if ($urandom_range(0, 99) < 7)
      put_sample(ACT_ACK, 1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
    clock_ms = base_ms + off;
    put_sample(ACT_SAMPLE, pin, clock_ms, 1'b0, '0);
  endtask

  // One random gesture: mostly well-formed clicks with random timing, some noise.
  task automatic run_gesture();
    int unsigned lp;
    int unsigned gp;
    int unsigned rel;
    int unsigned t2;
    int          kind;
    lp      = 32'(set_long_ms);
    gp      = 32'(set_gap_ms);
    kind    = $urandom_range(0, 9);
    base_ms = clock_ms + around(gp);
    case (kind)
      0, 1, 2: begin
        // Single click: short press, then highs around and past the gap.
        tap(1'b0, 0);
        rel = short_of(lp);
        repeat ($urandom_range(0, 2)) tap(1'b0, $urandom_range(0, rel));
        tap(1'b1, rel);
        tap(1'b1, rel + around(gp));
        tap(1'b1, rel + gp + 1 + $urandom_range(0, 100));
      end
      3, 4: begin
        // Double click: short press, quick second press, release.
        tap(1'b0, 0);
        rel = short_of(lp);
        tap(1'b1, rel);
        t2 = rel + short_of(gp);
        tap(1'b0, t2);
        if ($urandom_range(0, 1) == 0) tap(1'b0, t2 + $urandom_range(0, 500));
        tap(1'b1, t2 + around(lp));
      end
      5, 6: begin
        // Long click: release at or past the long press time.
        tap(1'b0, 0);
        if ($urandom_range(0, 1) == 0) tap(1'b0, $urandom_range(0, lp));
        rel = lp + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5000));
        tap(1'b1, rel);
      end
      7: begin
        // Late second press: lands at or after the gap and is ignored.
        tap(1'b0, 0);
        rel = short_of(lp);
        tap(1'b1, rel);
        tap(1'b0, rel + gp + $urandom_range(0, 50));
        tap(1'b1, rel + around(gp));
        tap(1'b1, rel + gp + 1 + $urandom_range(0, 100));
      end
      default: begin
        // Noise: random levels, random actions, times near or anywhere.
        repeat ($urandom_range(1, 4)) begin
          clock_ms = ($urandom_range(0, 1) == 0) ? clock_ms + $urandom_range(0, 300)
                                                  : time_t'($urandom);
          put_sample(($urandom_range(0, 4) == 0) ? ACT_ACK : ACT_SAMPLE,
                     1'($urandom_range(0, 1)), clock_ms, 1'b0, '0);
        end
      end
    endcase
    // Now and then let the pipeline run dry before going on.
    if ($urandom_range(0, 99) < 3) drain();
  endtask

  // Receiver: drop ready at random at the configured rate.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Score board and watchdog: everything is sampled at the rising edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic    moved;
    moved = 1'b0;
    if (!rst) begin
      // Results first, so a result never meets the expectation pushed this edge.
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got = '{result_ch.clicked, result_ch.double_clicked, result_ch.long_clicked,
                result_ch.phase};
        if (status_due.size() == 0) begin
          $error("result transaction with nothing expected: %p", got);
          n_fail++;
        end else begin
          want = status_due.pop_front();
          if (got.clicked !== want.clicked) begin
            $error("clicked: expected %0b, got %0b", want.clicked, got.clicked);
            n_fail++;
          end
          if (got.double_clicked !== want.double_clicked) begin
            $error("double_clicked: expected %0b, got %0b", want.double_clicked,
                   got.double_clicked);
            n_fail++;
          end
          if (got.long_clicked !== want.long_clicked) begin
            $error("long_clicked: expected %0b, got %0b", want.long_clicked,
                   got.long_clicked);
            n_fail++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            n_fail++;
          end
        end
      end
      if (reg_ch.valid && reg_ch.ready) begin
        moved = 1'b1;
        case (reg_ch.index)
          REG_LONG_PRESS: set_long_ms = reg_ch.data;
          REG_DOUBLE_GAP: set_gap_ms = reg_ch.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        moved = 1'b1;
        want = classify(sample_ch.action, sample_ch.pin_level, sample_ch.now_ms);
        status_due.push_back(row_chk ? row_lit : want);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [CFG_BITS-1:0] lp;
    logic [CFG_BITS-1:0] gp;

    // Known values on every input from time zero.
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.action    = ACT_SAMPLE;
    sample_ch.pin_level = 1'b1;
    sample_ch.now_ms    = '0;
    reg_ch.valid        = 1'b0;
    reg_ch.index        = '0;
    reg_ch.data         = '0;
    result_ch.ready     = 1'b0;
    row_chk             = 1'b0;
    row_lit             = '0;
    n_fail              = 0;
    quiet_cycles        = 0;
    items_sent          = 0;
    clock_ms            = '0;
    base_ms             = '0;
    tx_idle_pct         = 13;
    rx_idle_pct         = 72;

    st_phase      = PH_IDLE;
    st_press_ms   = '0;
    st_release_ms = '0;
    st_single     = 1'b0;
    st_double     = 1'b0;
    st_long       = 1'b0;
    set_long_ms   = LONG_PRESS_RESET;
    set_gap_ms    = DOUBLE_GAP_RESET;

    // Directed table, starting from the reset timings of 800 ms and 200 ms.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd0, status(0, 0, 0, PH_IDLE)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd1000, status(0, 0, 0, PH_PRESSED)));
    // Release one below the long press time.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd1799, status(0, 0, 0, PH_RELEASED)));
    // High exactly at the gap changes nothing; one past it is a single click.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd1999, status(0, 0, 0, PH_RELEASED)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd2000, status(1, 0, 0, PH_IDLE)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd3000, status(1, 0, 0, PH_PRESSED)));
    // Release exactly at the long press time.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd3800, status(1, 0, 1, PH_IDLE)));
    plan.push_back(lit_row(ACT_ACK, 1'b1, 32'd3900, status(0, 0, 0, PH_IDLE)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd4000, status(0, 0, 0, PH_PRESSED)));
    plan.push_back(free_row(ACT_SAMPLE, 1'b1, 32'd4100));
    // Second press one below the gap, held, then released: double click.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd4299, status(0, 0, 0, PH_SECOND)));
    plan.push_back(free_row(ACT_SAMPLE, 1'b0, 32'd4300));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd4350, status(0, 1, 0, PH_IDLE)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd5000, status(0, 1, 0, PH_PRESSED)));
    plan.push_back(free_row(ACT_SAMPLE, 1'b1, 32'd5001));
    // Late second press right at the gap stays released, then single click.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd5201, status(0, 1, 0, PH_RELEASED)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd5202, status(1, 1, 0, PH_IDLE)));
    // Acknowledge ignores pin and time.
    plan.push_back(lit_row(ACT_ACK, 1'b0, 32'hFFFF_FFFF, status(0, 0, 0, PH_IDLE)));
    // Press at the top of the time range, release after the wrap at 800 ms.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'hFFFF_FFFF, status(0, 0, 0, PH_PRESSED)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'h0000_031F, status(0, 0, 1, PH_IDLE)));
    // Zero timings; an ignored index write in between.
    plan.push_back(reg_row(REG_LONG_PRESS, 16'd0));
    plan.push_back(reg_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(reg_row(REG_DOUBLE_GAP, 16'd0));
    plan.push_back(lit_row(ACT_ACK, 1'b1, 32'd0, status(0, 0, 0, PH_IDLE)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd7, status(0, 0, 0, PH_PRESSED)));
    // Zero long press time: even an instant release is long.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd7, status(0, 0, 1, PH_IDLE)));
    plan.push_back(reg_row(REG_LONG_PRESS, 16'd800));
    plan.push_back(free_row(ACT_SAMPLE, 1'b0, 32'd10));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd11, status(0, 0, 1, PH_RELEASED)));
    // Zero gap: an instant second press cannot start a double click.
    plan.push_back(lit_row(ACT_SAMPLE, 1'b0, 32'd11, status(0, 0, 1, PH_RELEASED)));
    plan.push_back(lit_row(ACT_SAMPLE, 1'b1, 32'd12, status(1, 0, 1, PH_IDLE)));

    // Synchronous reset held from time zero, then released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        put_sample(plan[i].act, plan[i].pin, plan[i].t, plan[i].chk, plan[i].lit);
      end
    end
    clock_ms = 32'd12;

    // Random part: nine segments, three per idling pattern, each with its own timings.
    for (int seg = 0; seg < 9; seg++) begin
      int target;
      case (seg / 3)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          lp = LONG_PRESS_RESET;
          gp = DOUBLE_GAP_RESET;
        end
        1: begin
          lp = 16'd1;
          gp = 16'd1;
        end
        2: begin
          lp = 16'hFFFF;
          gp = 16'hFFFF;
        end
        4: begin
          lp = 16'hFFFF;
          gp = 16'd1;
        end
        5: begin
          lp = 16'd1;
          gp = 16'hFFFF;
        end
        6: begin
          lp = CFG_BITS'($urandom_range(1, 16'hFFFF));
          gp = CFG_BITS'($urandom_range(1, 16'hFFFF));
        end
        default: begin
          lp = CFG_BITS'($urandom_range(1, 3000));
          gp = CFG_BITS'($urandom_range(1, 3000));
        end
      endcase
      set_regs(lp, gp);
      // Start some segments just below the wrap of the millisecond counter.
      if (seg % 2 == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      target = items_sent + SEG_ITEMS;
      while (items_sent < target) run_gesture();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
